/* sv/sawt_pkg.sv */
`default_nettype none
package sawt_pkg;

   typedef enum logic [1:0] {
      KIND_SENT    = 2'd0,
      KIND_ACKED   = 2'd1,
      KIND_DROPPED = 2'd2,
      KIND_RX_DONE = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEND_HDR,
      ST_SEND_DROP,
      ST_SEND_SHIFT,
      ST_SEND_APPEND,
      ST_RX_SCAN,
      ST_RX_READ,
      ST_RX_CHECK,
      ST_RX_DIV,
      ST_RX_EMIT,
      ST_RX_SHIFT,
      ST_RX_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic send_begin;
      logic rx_begin;
      logic rd_scan;
      logic check_hit;
      logic div_start;
      logic emit;
      kind_type emit_kind;
      logic emit_last;
      logic shift_step;
      logic shift_begin;
      logic append;
      logic scan_dec;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic func;
      logic full;
      logic scan_zero;
      logic hit;
      logic div_done;
      logic shift_done;
      logic out_busy;
   } status_type;

   localparam int unsigned SeqWidth = 32;
   localparam int unsigned SumWidth = 48;
   localparam int unsigned MaxJump  = 32;

endpackage : sawt_pkg
`default_nettype wire

/* sv/sawt_divider.sv */
`default_nettype none
module sawt_divider
   import sawt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [SumWidth-1:0] dividend,
   input  wire logic [SeqWidth-1:0] divisor,
   output logic                     done,
   output logic [SeqWidth-1:0]      quotient
);

   logic [SumWidth-1:0] quo_ff, quo_in;
   logic [SeqWidth:0]   rem_ff, rem_in;
   logic [SeqWidth-1:0] dsr_ff, dsr_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [SeqWidth+1:0] trial;
   logic [SeqWidth:0]   shifted;

   // one quotient bit per cycle, restoring
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[SeqWidth-1:0], quo_ff[SumWidth-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 6'(SumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[SeqWidth+1]) begin
            rem_in = trial[SeqWidth:0];
            quo_in = {quo_ff[SumWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[SumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = !busy_ff;
   assign quotient = quo_ff[SeqWidth-1:0];

endmodule : sawt_divider
`default_nettype wire

/* sv/sawt_datapath.sv */
`default_nettype none
module sawt_datapath
   import sawt_pkg::*;
#(
   parameter int unsigned PENDING_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output status_type         status,
   input  wire logic          req_tuser,
   input  wire logic [127:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [167:0]       rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);

   localparam int unsigned IdxW = $clog2(PENDING_DEPTH);
   localparam int unsigned CntW = $clog2(PENDING_DEPTH + 1);

   // item registers
   logic                func_ff;
   logic [SeqWidth-1:0] now_ff, rseq_ff, rack_ff, rbits_ff;

   // tracker state
   logic [SeqWidth-1:0] local_seq_ff, latest_ff, bitfield_ff;
   logic [SeqWidth-1:0] acked_ff, mean_ff;
   logic [SumWidth-1:0] sum_ff;
   logic [CntW-1:0]     count_ff;

   // pending store, separate arrays for seq and time, one write port each
   logic [SeqWidth-1:0] mem_seq [PENDING_DEPTH];
   logic [SeqWidth-1:0] mem_time [PENDING_DEPTH];
   logic [SeqWidth-1:0] rd_seq_ff, rd_time_ff;
   logic [IdxW-1:0]     rd_addr, wr_addr;
   logic                wr_en;
   logic [SeqWidth-1:0] wr_seq, wr_time;

   // scan and shift pointers
   logic [CntW-1:0]     scan_ff;
   logic [CntW-1:0]     sh_ff;
   logic                sh_phase_ff;
   logic [SeqWidth-1:0] hit_seq_ff, hit_rtt_ff, drop_seq_ff;
   logic                hit_ff;

   // output register
   logic                ovalid_ff;
   logic [167:0]        odata_ff;
   logic [1:0]          ouser_ff;
   logic                olast_ff;

   // divider
   logic                div_done;
   logic [SeqWidth-1:0] div_q;

   // running sum with the current round trip, saturated
   logic [SumWidth:0]   sum_add;
   logic [SumWidth-1:0] sum_sat;
   assign sum_add = {1'b0, sum_ff} + {{(SumWidth-SeqWidth+1){1'b0}}, hit_rtt_ff};
   assign sum_sat = sum_add[SumWidth] ? '1 : sum_add[SumWidth-1:0];

   sawt_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(sum_sat),
      .divisor (acked_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   // remote sequence window update
   logic [SeqWidth-1:0] diff, ndiff;
   logic [SeqWidth-1:0] bf_next;
   logic                take_seq;
   always_comb begin
      diff     = rseq_ff - latest_ff;
      ndiff    = -diff;
      bf_next  = bitfield_ff;
      take_seq = 1'b0;
      if (!diff[SeqWidth-1] && diff != '0 && diff <= SeqWidth'(MaxJump)) begin
         bf_next  = ({bitfield_ff[SeqWidth-2:0], 1'b1}) << (diff[5:0] - 6'd1);
         take_seq = 1'b1;
      end else if (diff[SeqWidth-1] && ndiff <= SeqWidth'(MaxJump)) begin
         bf_next  = bitfield_ff | (SeqWidth'(1) << (ndiff[5:0] - 6'd1));
      end else if (!diff[SeqWidth-1] && diff != '0) begin
         bf_next  = '0;
         take_seq = 1'b1;
      end
   end

   // match check on the entry just read
   logic [SeqWidth-1:0] e;
   logic                hit_comb;
   always_comb begin
      e        = rack_ff - rd_seq_ff;
      hit_comb = (e == '0) ||
                 (!e[SeqWidth-1] && e <= SeqWidth'(MaxJump) && rbits_ff[e[4:0] - 5'd1]);
   end

   // memory address selection
   always_comb begin
      rd_addr = scan_ff[IdxW-1:0] - IdxW'(1);
      if (cmd.shift_step) rd_addr = IdxW'(sh_ff + CntW'(1));
      else if (cmd.send_begin) rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = IdxW'(sh_ff);
      wr_seq  = rd_seq_ff;
      wr_time = rd_time_ff;
      if (cmd.shift_step && sh_phase_ff) wr_en = 1'b1;
      if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = IdxW'(count_ff);
         wr_seq  = local_seq_ff;
         wr_time = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_seq[wr_addr]  <= wr_seq;
         mem_time[wr_addr] <= wr_time;
      end
      rd_seq_ff  <= mem_seq[rd_addr];
      rd_time_ff <= mem_time[rd_addr];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_seq_ff <= '0;
         latest_ff    <= '0;
         bitfield_ff  <= '0;
         acked_ff     <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovalid_ff    <= 1'b0;
         scan_ff      <= '0;
         sh_ff        <= '0;
         sh_phase_ff  <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         if (cmd.emit) ovalid_ff <= 1'b1;
         else if (rsp_tvalid && rsp_tready) ovalid_ff <= 1'b0;
         if (cmd.send_begin) begin
            local_seq_ff <= local_seq_ff + SeqWidth'(1);
         end
         if (cmd.rx_begin) begin
            bitfield_ff <= bf_next;
            if (take_seq) latest_ff <= rseq_ff;
            scan_ff <= count_ff;
         end
         if (cmd.scan_dec) scan_ff <= scan_ff - CntW'(1);
         if (cmd.check_hit) begin
            hit_ff <= hit_comb;
            if (hit_comb) begin
               if (acked_ff != '1) acked_ff <= acked_ff + SeqWidth'(1);
               sh_ff <= scan_ff - CntW'(1);
            end
         end
         if (cmd.div_start) sum_ff <= sum_sat;
         if (cmd.emit && cmd.emit_kind == KIND_ACKED) begin
            mean_ff  <= div_q;
            count_ff <= count_ff - CntW'(1);
         end
         if (cmd.shift_begin) begin
            if (!func_ff) sh_ff <= '0;
            sh_phase_ff <= 1'b0;
            if (!func_ff) count_ff <= count_ff - CntW'(1);
         end
         if (cmd.shift_step) begin
            sh_phase_ff <= !sh_phase_ff;
            if (sh_phase_ff) sh_ff <= sh_ff + CntW'(1);
         end
         if (cmd.append) count_ff <= count_ff + CntW'(1);
      end
   end

   // payload fields, combinational
   logic [SeqWidth-1:0] o_seq, o_rtt;
   logic [CntW-1:0]     o_left;
   always_comb begin
      o_seq  = '0;
      o_rtt  = '0;
      o_left = count_ff;
      unique case (cmd.emit_kind)
         KIND_SENT: begin
            o_seq  = local_seq_ff + SeqWidth'(1);
            o_left = count_ff + CntW'(1);
            if (status.full) o_left = count_ff;
         end
         KIND_DROPPED: o_seq = drop_seq_ff;
         KIND_ACKED: begin
            o_seq  = hit_seq_ff;
            o_rtt  = hit_rtt_ff;
            o_left = count_ff - CntW'(1);
         end
         KIND_RX_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff  <= req_tuser;
         now_ff   <= req_tdata[31:0];
         rseq_ff  <= req_tdata[63:32];
         rack_ff  <= req_tdata[95:64];
         rbits_ff <= req_tdata[127:96];
      end
      if (cmd.send_begin) drop_seq_ff <= mem_seq[0];
      if (cmd.check_hit) begin
         hit_seq_ff <= rd_seq_ff;
         hit_rtt_ff <= now_ff - rd_time_ff;
      end
      if (cmd.emit) begin
         olast_ff <= cmd.emit_last;
         ouser_ff <= cmd.emit_kind;
         odata_ff <= {3'b000, 5'(o_left),
                      (cmd.emit_kind == KIND_ACKED) ? div_q : mean_ff,
                      o_rtt, bitfield_ff, latest_ff, o_seq};
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;

   assign status.func       = func_ff;
   assign status.full       = count_ff >= CntW'(PENDING_DEPTH);
   assign status.scan_zero  = scan_ff == '0;
   assign status.hit        = hit_ff;
   assign status.div_done   = div_done;
   assign status.shift_done = sh_ff >= count_ff;
   assign status.out_busy   = ovalid_ff && !rsp_tready;

endmodule : sawt_datapath
`default_nettype wire

/* sv/sawt_controller.sv */
`default_nettype none
module sawt_controller
   import sawt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      drop_ff, drop_in;
   logic      div_go_ff, div_go_in;

   // next state
   always_comb begin
      state_in = state_ff;
      drop_in  = drop_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_tvalid) state_in = ST_SEND_HDR;
         ST_SEND_HDR: begin
            if (status.func) state_in = ST_RX_SCAN;
            else if (!status.out_busy) begin
               drop_in  = status.full;
               state_in = status.full ? ST_SEND_DROP : ST_SEND_APPEND;
            end
         end
         ST_SEND_DROP:
            if (!status.out_busy) state_in = ST_SEND_SHIFT;
         ST_SEND_SHIFT:
            if (status.shift_done) state_in = ST_SEND_APPEND;
         ST_SEND_APPEND: state_in = ST_IDLE;
         ST_RX_SCAN:
            state_in = status.scan_zero ? ST_RX_DONE : ST_RX_READ;
         ST_RX_READ: state_in = ST_RX_CHECK;
         ST_RX_CHECK: state_in = ST_RX_DIV;
         ST_RX_DIV:
            if (!status.hit) state_in = ST_RX_SCAN;
            else if (status.div_done && !div_go_ff) state_in = ST_RX_EMIT;
         ST_RX_EMIT:
            if (!status.out_busy) state_in = ST_RX_SHIFT;
         ST_RX_SHIFT:
            if (status.shift_done) state_in = ST_RX_SCAN;
         ST_RX_DONE:
            if (!status.out_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.emit_kind = KIND_RX_DONE;
      req_tready = 1'b0;
      div_go_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_SEND_HDR: begin
            cmd.emit_kind = KIND_SENT;
            if (status.func) cmd.rx_begin = 1'b1;
            else if (!status.out_busy) begin
               cmd.send_begin = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_last  = !status.full;
            end
         end
         ST_SEND_DROP: begin
            cmd.emit_kind = KIND_DROPPED;
            if (!status.out_busy) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.shift_begin = 1'b1;
            end
         end
         ST_SEND_SHIFT: cmd.shift_step = !status.shift_done;
         ST_SEND_APPEND: cmd.append = 1'b1;
         ST_RX_SCAN: ;
         ST_RX_READ: cmd.rd_scan = 1'b1;
         ST_RX_CHECK: begin
            cmd.check_hit = 1'b1;
            cmd.scan_dec  = 1'b1;
            div_go_in     = 1'b1;
         end
         ST_RX_DIV: cmd.div_start = div_go_ff && status.hit;
         ST_RX_EMIT: begin
            cmd.emit_kind = KIND_ACKED;
            if (!status.out_busy) begin
               cmd.emit        = 1'b1;
               cmd.shift_begin = 1'b1;
            end
         end
         ST_RX_SHIFT: cmd.shift_step = !status.shift_done;
         ST_RX_DONE: begin
            cmd.emit_kind = KIND_RX_DONE;
            if (!status.out_busy) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         drop_ff   <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         drop_ff   <= drop_in;
         div_go_ff <= div_go_in;
      end
   end

   // only idle takes a new transaction
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   // an emit never happens while output is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.out_busy) else $error("result overrun");
   // a drop always follows a full store
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEND_DROP |-> drop_ff) else $error("drop without full");

endmodule : sawt_controller
`default_nettype wire

/* sv/selective_ack_window_tracker.sv */
`default_nettype none
// Selective-ack tracker for one peer. A send transaction (req_tuser = 0) gives a
// header result and, when the pending store is full, a dropped result; with a
// drop the remaining entries move down. A receive transaction updates the remote
// window, then scans the pending store newest to oldest; for each acknowledged
// entry a bit-serial divider forms the mean, then the newer entries move down
// over the single write port. A stalled result channel holds the transaction up.
// One transaction is handled at a time; ready is high only when idle.
module selective_ack_window_tracker
   import sawt_pkg::*;
#(
   parameter int unsigned PENDING_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_tuser,   // func
   // now_time, remote_seq, remote_ack, remote_ack_bits
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // seq_number, ack_seq_out, ack_bits_out, round_trip, average_rtt,
   // pending_left, zero padding
   output logic [167:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,   // kind
   output logic              rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   sawt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sawt_datapath #(.PENDING_DEPTH(PENDING_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule : selective_ack_window_tracker
`default_nettype wire
